>>> rtl/obbsat_pkg.sv
// ----------------------------------------------------------------------------
// obbsat_pkg
// Shared constants for the oriented box separating axis test pipeline.
// ----------------------------------------------------------------------------
package obbsat_pkg;

   // Axis components are signed Q1.x words of fixed width.
   localparam int AXIS_WIDTH = 16;

   // Number of register stages from an accepted word to its result.
   localparam int PIPE_DEPTH = 7;

endpackage

>>> rtl/obb_obb_separating_axis_test_top.sv
// A word accepted at a clock edge gives its result on rsp_hit with rsp_valid once it
// has passed through the seven register stages.
// Throughput: one word per cycle; every multiplier serves one word per cycle.
// Reset is synchronous: it clears the valid bits, so no result leaves after it,
// and busy is high only while reset is high. The receiver cannot stall.
// ----------------------------------------------------------------------------
// obb_obb_separating_axis_test_top
// Pipelined 2D oriented box overlap test over the four box axes.
// ----------------------------------------------------------------------------
module obb_obb_separating_axis_test_top
   import obbsat_pkg::*;
#(
   parameter int COORD_WIDTH    = 24,
   parameter int AXIS_FRAC_BITS = 14
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_a_center_x,
   input  logic signed [COORD_WIDTH-1:0] req_a_center_y,
   input  logic signed [AXIS_WIDTH-1:0]  req_a_cos,
   input  logic signed [AXIS_WIDTH-1:0]  req_a_sin,
   input  logic [COORD_WIDTH-2:0]        req_a_half_w,
   input  logic [COORD_WIDTH-2:0]        req_a_half_h,
   input  logic signed [COORD_WIDTH-1:0] req_b_center_x,
   input  logic signed [COORD_WIDTH-1:0] req_b_center_y,
   input  logic signed [AXIS_WIDTH-1:0]  req_b_cos,
   input  logic signed [AXIS_WIDTH-1:0]  req_b_sin,
   input  logic [COORD_WIDTH-2:0]        req_b_half_w,
   input  logic [COORD_WIDTH-2:0]        req_b_half_h,
   output logic                          rsp_valid,
   output logic                          rsp_hit
);

   localparam int HW    = COORD_WIDTH - 1;
   localparam int DW    = COORD_WIDTH + 1;
   localparam int PW    = DW + AXIS_WIDTH;
   localparam int SW    = PW + 1;
   localparam int DOTW  = 2 * AXIS_WIDTH + 1;
   localparam int DMAGW = 2 * AXIS_WIDTH;

   logic                       accept;
   logic [PIPE_DEPTH-1:0]      vld_in;
   logic [PIPE_DEPTH-1:0]      vld_ff;

   // Stage 1: center difference and captured axes.
   logic signed [DW-1:0]         dx_in;
   logic signed [DW-1:0]         dy_in;
   logic signed [DW-1:0]         dx_ff;
   logic signed [DW-1:0]         dy_ff;
   logic signed [AXIS_WIDTH-1:0] ac_ff;
   logic signed [AXIS_WIDTH-1:0] as_ff;
   logic signed [AXIS_WIDTH-1:0] bc_ff;
   logic signed [AXIS_WIDTH-1:0] bs_ff;

   // Half lengths ride along to the lanes: aw, ah, bw, bh.
   logic [HW-1:0]                half_ff [4][4];

   // Stage 2: products.
   logic signed [PW-1:0]         prod_in [8];
   logic signed [PW-1:0]         prod_ff [8];
   logic signed [DMAGW-1:0]      dot_in  [4];
   logic signed [DMAGW-1:0]      dot_ff  [4];

   // Stage 3: projections and the dot and cross products of the two axes.
   logic signed [SW-1:0]         proj_in [4];
   logic signed [SW-1:0]         proj_ff [4];
   logic signed [DOTW-1:0]       pq_in   [2];
   logic signed [DOTW-1:0]       pq_ff   [2];

   // Stage 4: magnitudes.
   logic signed [SW-1:0]         proj_neg [4];
   logic signed [DOTW-1:0]       pq_neg   [2];
   logic [SW-1:0]                pmag_in  [4];
   logic [SW-1:0]                pmag_ff  [4];
   logic [DMAGW-1:0]             dmag_in  [2];
   logic [DMAGW-1:0]             dmag_ff  [2];

   logic [3:0]                   sep;

   assign busy   = reset;
   assign accept = start && !busy;
   assign vld_in = {vld_ff[PIPE_DEPTH-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign dx_in = {req_a_center_x[COORD_WIDTH-1], req_a_center_x}
                - {req_b_center_x[COORD_WIDTH-1], req_b_center_x};
   assign dy_in = {req_a_center_y[COORD_WIDTH-1], req_a_center_y}
                - {req_b_center_y[COORD_WIDTH-1], req_b_center_y};

   // Axis A x uses (ac, as), A y (-as, ac), B x (bc, bs), B y (-bs, bc).
   always_comb begin
      prod_in[0] = dx_ff * ac_ff;
      prod_in[1] = dy_ff * as_ff;
      prod_in[2] = dx_ff * as_ff;
      prod_in[3] = dy_ff * ac_ff;
      prod_in[4] = dx_ff * bc_ff;
      prod_in[5] = dy_ff * bs_ff;
      prod_in[6] = dx_ff * bs_ff;
      prod_in[7] = dy_ff * bc_ff;
      dot_in[0]  = ac_ff * bc_ff;
      dot_in[1]  = as_ff * bs_ff;
      dot_in[2]  = as_ff * bc_ff;
      dot_in[3]  = ac_ff * bs_ff;
   end

   // Every cross-box extent term is |P| or |Q| with P = a.b and Q = a x b.
   always_comb begin
      proj_in[0] = {prod_ff[0][PW-1], prod_ff[0]} + {prod_ff[1][PW-1], prod_ff[1]};
      proj_in[1] = {prod_ff[3][PW-1], prod_ff[3]} - {prod_ff[2][PW-1], prod_ff[2]};
      proj_in[2] = {prod_ff[4][PW-1], prod_ff[4]} + {prod_ff[5][PW-1], prod_ff[5]};
      proj_in[3] = {prod_ff[7][PW-1], prod_ff[7]} - {prod_ff[6][PW-1], prod_ff[6]};
      pq_in[0]   = {dot_ff[0][DMAGW-1], dot_ff[0]} + {dot_ff[1][DMAGW-1], dot_ff[1]};
      pq_in[1]   = {dot_ff[2][DMAGW-1], dot_ff[2]} - {dot_ff[3][DMAGW-1], dot_ff[3]};
   end

   // The magnitudes fit unsigned in the same or one bit fewer.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         proj_neg[i] = -proj_ff[i];
         pmag_in[i]  = proj_ff[i][SW-1] ? proj_neg[i] : proj_ff[i];
      end
      for (int j = 0; j < 2; j++) begin
         pq_neg[j]  = -pq_ff[j];
         dmag_in[j] = pq_ff[j][DOTW-1] ? pq_neg[j][DMAGW-1:0] : pq_ff[j][DMAGW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      ac_ff <= req_a_cos;
      as_ff <= req_a_sin;
      bc_ff <= req_b_cos;
      bs_ff <= req_b_sin;
      half_ff[0][0] <= req_a_half_w;
      half_ff[0][1] <= req_a_half_h;
      half_ff[0][2] <= req_b_half_w;
      half_ff[0][3] <= req_b_half_h;
      for (int s = 1; s < 4; s++) begin
         for (int k = 0; k < 4; k++) begin
            half_ff[s][k] <= half_ff[s-1][k];
         end
      end
      for (int i = 0; i < 8; i++) begin
         prod_ff[i] <= prod_in[i];
      end
      for (int i = 0; i < 4; i++) begin
         dot_ff[i]  <= dot_in[i];
         proj_ff[i] <= proj_in[i];
         pmag_ff[i] <= pmag_in[i];
      end
      for (int j = 0; j < 2; j++) begin
         pq_ff[j]   <= pq_in[j];
         dmag_ff[j] <= dmag_in[j];
      end
   end

   obbsat_axis_lane #(
      .COORD_WIDTH    (COORD_WIDTH),
      .AXIS_FRAC_BITS (AXIS_FRAC_BITS)
   ) u_lane_ax (
      .clock    (clock),
      .proj_mag (pmag_ff[0]),
      .dot_e0   (dmag_ff[0]),
      .dot_e1   (dmag_ff[1]),
      .own_half (half_ff[3][0]),
      .oth_w    (half_ff[3][2]),
      .oth_h    (half_ff[3][3]),
      .sep      (sep[0])
   );

   obbsat_axis_lane #(
      .COORD_WIDTH    (COORD_WIDTH),
      .AXIS_FRAC_BITS (AXIS_FRAC_BITS)
   ) u_lane_ay (
      .clock    (clock),
      .proj_mag (pmag_ff[1]),
      .dot_e0   (dmag_ff[1]),
      .dot_e1   (dmag_ff[0]),
      .own_half (half_ff[3][1]),
      .oth_w    (half_ff[3][2]),
      .oth_h    (half_ff[3][3]),
      .sep      (sep[1])
   );

   obbsat_axis_lane #(
      .COORD_WIDTH    (COORD_WIDTH),
      .AXIS_FRAC_BITS (AXIS_FRAC_BITS)
   ) u_lane_bx (
      .clock    (clock),
      .proj_mag (pmag_ff[2]),
      .dot_e0   (dmag_ff[0]),
      .dot_e1   (dmag_ff[1]),
      .own_half (half_ff[3][2]),
      .oth_w    (half_ff[3][0]),
      .oth_h    (half_ff[3][1]),
      .sep      (sep[2])
   );

   obbsat_axis_lane #(
      .COORD_WIDTH    (COORD_WIDTH),
      .AXIS_FRAC_BITS (AXIS_FRAC_BITS)
   ) u_lane_by (
      .clock    (clock),
      .proj_mag (pmag_ff[3]),
      .dot_e0   (dmag_ff[1]),
      .dot_e1   (dmag_ff[0]),
      .own_half (half_ff[3][3]),
      .oth_w    (half_ff[3][0]),
      .oth_h    (half_ff[3][1]),
      .sep      (sep[3])
   );

   assign rsp_valid = vld_ff[PIPE_DEPTH-1];
   assign rsp_hit   = rsp_valid && !(|sep);

endmodule

>>> rtl/obbsat_axis_lane.sv
// ----------------------------------------------------------------------------
// obbsat_axis_lane
// Back half of one axis test: scales the other box's half lengths by the
// axis dot products, forms the reach and compares it with the projection.
// ----------------------------------------------------------------------------
module obbsat_axis_lane
   import obbsat_pkg::*;
#(
   parameter int COORD_WIDTH    = 24,
   parameter int AXIS_FRAC_BITS = 14
) (
   input  logic                                  clock,
   input  logic [COORD_WIDTH+AXIS_WIDTH+1:0]     proj_mag,
   input  logic [2*AXIS_WIDTH-1:0]               dot_e0,
   input  logic [2*AXIS_WIDTH-1:0]               dot_e1,
   input  logic [COORD_WIDTH-2:0]                own_half,
   input  logic [COORD_WIDTH-2:0]                oth_w,
   input  logic [COORD_WIDTH-2:0]                oth_h,
   output logic                                  sep
);

   localparam int HW   = COORD_WIDTH - 1;
   localparam int MW   = COORD_WIDTH + AXIS_WIDTH + 2;
   localparam int EW   = 2 * AXIS_WIDTH + HW;
   localparam int RW   = EW + 2;
   localparam int PSW  = MW + AXIS_FRAC_BITS;
   localparam int CMPW = (RW > PSW) ? RW : PSW;

   logic [EW-1:0]   e0_in;
   logic [EW-1:0]   e1_in;
   logic [EW-1:0]   e0_ff;
   logic [EW-1:0]   e1_ff;
   logic [HW-1:0]   own_ff;
   logic [MW-1:0]   proj_a_ff;
   logic [RW-1:0]   reach_in;
   logic [RW-1:0]   reach_ff;
   logic [MW-1:0]   proj_b_ff;
   logic            sep_in;
   logic            sep_ff;

   assign e0_in = dot_e0 * oth_w;
   assign e1_in = dot_e1 * oth_h;

   // The own half length is aligned to the extent scale of 2*frac bits.
   assign reach_in = (RW'(own_ff) << (2 * AXIS_FRAC_BITS))
                   + RW'(e0_ff) + RW'(e1_ff);

   assign sep_in = (CMPW'(proj_b_ff) << AXIS_FRAC_BITS) > CMPW'(reach_ff);

   always_ff @(posedge clock) begin
      e0_ff     <= e0_in;
      e1_ff     <= e1_in;
      own_ff    <= own_half;
      proj_a_ff <= proj_mag;
      reach_ff  <= reach_in;
      proj_b_ff <= proj_a_ff;
      sep_ff    <= sep_in;
   end

   assign sep = sep_ff;

endmodule

>>> rtl/obbsat_checker.sv
// ----------------------------------------------------------------------------
// obbsat_checker
// Port-level timing checks for the box overlap pipeline, bound to the top.
// ----------------------------------------------------------------------------
module obbsat_checker
   import obbsat_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_hit
);

   // Nothing left in the pipeline survives a reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   // Every accepted word comes out at the end of the pipeline.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_DEPTH rsp_valid)
      else $error("accepted word produced no result");

   // No result appears without a matching word accepted earlier.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_DEPTH))
      else $error("result without a matching accepted word");

   // The hit flag is quiet between results.
   assert property (@(posedge clock) !rsp_valid |-> !rsp_hit)
      else $error("hit raised without result strobe");

endmodule

bind obb_obb_separating_axis_test_top obbsat_checker u_checker (.*);

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the oriented box overlap pipeline. A queue of box
// pairs (a directed set, then random near pairs, edge-contact pairs and raw
// bit patterns) feeds a clocked driver; a clocked monitor compares every
// rsp_hit against an overlap predictor evaluated on each accepted word.
// ----------------------------------------------------------------------------
module tb_top
   import obbsat_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_W     = 24;
   localparam int HALF_W      = COORD_W - 1;
   localparam int FRAC_BITS   = 14;
   localparam int ONE_AXIS    = 1 << FRAC_BITS;
   localparam int RANDOM_N    = 1050;
   localparam int MID_DRAIN   = 600;
   localparam int QUIET_FROM  = 300;
   localparam int QUIET_TO    = 520;

   typedef struct {
      logic signed [COORD_W-1:0]    cx;
      logic signed [COORD_W-1:0]    cy;
      logic signed [AXIS_WIDTH-1:0] cos_u;
      logic signed [AXIS_WIDTH-1:0] sin_u;
      logic [COORD_W-2:0]           half_w;
      logic [COORD_W-2:0]           half_h;
   } box_type;

   typedef struct {
      box_type a;
      box_type b;
   } box_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [COORD_W-1:0]    req_a_center_x = '0;
   logic signed [COORD_W-1:0]    req_a_center_y = '0;
   logic signed [AXIS_WIDTH-1:0] req_a_cos      = '0;
   logic signed [AXIS_WIDTH-1:0] req_a_sin      = '0;
   logic [COORD_W-2:0]           req_a_half_w   = '0;
   logic [COORD_W-2:0]           req_a_half_h   = '0;
   logic signed [COORD_W-1:0]    req_b_center_x = '0;
   logic signed [COORD_W-1:0]    req_b_center_y = '0;
   logic signed [AXIS_WIDTH-1:0] req_b_cos      = '0;
   logic signed [AXIS_WIDTH-1:0] req_b_sin      = '0;
   logic [COORD_W-2:0]           req_b_half_w   = '0;
   logic [COORD_W-2:0]           req_b_half_h   = '0;
   logic rsp_valid;
   logic rsp_hit;

   box_pair_type pair_q[$];
   bit           hit_expected_q[$];
   box_pair_type cur_pair;
   int           total_words;
   int           directed_words;
   int           words_sent;
   int           results_seen;
   int           failures;

   obb_obb_separating_axis_test_top #(
      .COORD_WIDTH   (COORD_W),
      .AXIS_FRAC_BITS(FRAC_BITS)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_a_center_x(req_a_center_x),
      .req_a_center_y(req_a_center_y),
      .req_a_cos     (req_a_cos),
      .req_a_sin     (req_a_sin),
      .req_a_half_w  (req_a_half_w),
      .req_a_half_h  (req_a_half_h),
      .req_b_center_x(req_b_center_x),
      .req_b_center_y(req_b_center_y),
      .req_b_cos     (req_b_cos),
      .req_b_sin     (req_b_sin),
      .req_b_half_w  (req_b_half_w),
      .req_b_half_h  (req_b_half_h),
      .rsp_valid     (rsp_valid),
      .rsp_hit       (rsp_hit)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Overlap predictor
   // ------------------------------------------------------------------------
   function automatic longint unsigned magnitude(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   // True when axis (ux, uy) splits the boxes. own_half belongs to the box
   // that owns the axis; (oc, os, ow, oh) describe the other box.
   function automatic bit axis_separates(longint ux, longint uy,
                                         longint unsigned own_half,
                                         longint oc, longint os,
                                         longint unsigned ow, longint unsigned oh,
                                         longint dx, longint dy);
      longint unsigned proj;
      longint unsigned ext_w;
      longint unsigned ext_h;
      longint unsigned reach;
      proj  = magnitude(dx * ux + dy * uy);
      ext_w = magnitude(oc * ux + os * uy) * ow;
      ext_h = magnitude(-os * ux + oc * uy) * oh;
      reach = (own_half << (2 * FRAC_BITS)) + ext_w + ext_h;
      // The projection has FRAC_BITS fewer fraction bits than the extents.
      if ((proj >> (64 - FRAC_BITS)) != 0)
         return 1'b1;
      return (proj << FRAC_BITS) > reach;
   endfunction

   function automatic bit boxes_overlap(box_pair_type p);
      longint ac, as_, bc, bs, dx, dy;
      longint unsigned aw, ah, bw, bh;
      bit split;
      ac  = longint'(p.a.cos_u);
      as_ = longint'(p.a.sin_u);
      bc  = longint'(p.b.cos_u);
      bs  = longint'(p.b.sin_u);
      aw  = longint'(p.a.half_w);
      ah  = longint'(p.a.half_h);
      bw  = longint'(p.b.half_w);
      bh  = longint'(p.b.half_h);
      dx  = longint'(p.a.cx) - longint'(p.b.cx);
      dy  = longint'(p.a.cy) - longint'(p.b.cy);
      split = axis_separates(ac, as_, aw, bc, bs, bw, bh, dx, dy)
           || axis_separates(-as_, ac, ah, bc, bs, bw, bh, dx, dy)
           || axis_separates(bc, bs, bw, ac, as_, aw, ah, dx, dy)
           || axis_separates(-bs, bc, bh, ac, as_, aw, ah, dx, dy);
      return !split;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus builders
   // ------------------------------------------------------------------------
   function automatic box_type mk_box(int cx, int cy, int c, int s, int hw, int hh);
      box_type b;
      b.cx     = COORD_W'(cx);
      b.cy     = COORD_W'(cy);
      b.cos_u  = AXIS_WIDTH'(c);
      b.sin_u  = AXIS_WIDTH'(s);
      b.half_w = HALF_W'(hw);
      b.half_h = HALF_W'(hh);
      return b;
   endfunction

   function automatic box_pair_type mk_pair(box_type a, box_type b);
      box_pair_type p;
      p.a = a;
      p.b = b;
      return p;
   endfunction

   function automatic box_type unit_axis(box_type b);
      real ang;
      ang = real'($urandom_range(0, 3599)) * 3.14159265358979 / 1800.0;
      b.cos_u = AXIS_WIDTH'(int'($cos(ang) * real'(ONE_AXIS)));
      b.sin_u = AXIS_WIDTH'(int'($sin(ang) * real'(ONE_AXIS)));
      return b;
   endfunction

   // Two boxes whose centers lie within reach of each other, so that both
   // outcomes are common. Axes are either proper rotations or raw bits.
   function automatic box_pair_type near_pair(int half_max, bit unit_axes);
      box_pair_type p;
      int span;
      int base_x;
      int base_y;
      span   = 2 * half_max + 1;
      base_x = int'($urandom_range(0, 1 << 22)) - (1 << 21);
      base_y = int'($urandom_range(0, 1 << 22)) - (1 << 21);
      p.a = mk_box(base_x, base_y, 0, 0, $urandom_range(0, half_max),
                   $urandom_range(0, half_max));
      p.b = mk_box(base_x + int'($urandom_range(0, 2 * span)) - span,
                   base_y + int'($urandom_range(0, 2 * span)) - span, 0, 0,
                   $urandom_range(0, half_max), $urandom_range(0, half_max));
      if (unit_axes) begin
         p.a = unit_axis(p.a);
         p.b = unit_axis(p.b);
      end else begin
         p.a.cos_u = AXIS_WIDTH'($urandom());
         p.a.sin_u = AXIS_WIDTH'($urandom());
         p.b.cos_u = AXIS_WIDTH'($urandom());
         p.b.sin_u = AXIS_WIDTH'($urandom());
      end
      return p;
   endfunction

   // Axis-aligned boxes placed edge to edge, or nudged by one LSB either way.
   function automatic box_pair_type contact_pair();
      box_pair_type p;
      int gap;
      int slide;
      p.a = mk_box(int'($urandom_range(0, 1 << 22)) - (1 << 21),
                   int'($urandom_range(0, 1 << 22)) - (1 << 21),
                   $urandom_range(0, 1) ? ONE_AXIS : -ONE_AXIS, 0,
                   $urandom_range(0, 4095), $urandom_range(0, 4095));
      p.b = mk_box(0, 0, $urandom_range(0, 1) ? ONE_AXIS : -ONE_AXIS, 0,
                   $urandom_range(0, 4095), $urandom_range(0, 4095));
      if ($urandom_range(0, 1)) begin
         gap   = int'(p.a.half_w) + int'(p.b.half_w) + int'($urandom_range(0, 2)) - 1;
         slide = int'(p.a.half_h) + int'(p.b.half_h);
         p.b.cx = COORD_W'(int'(p.a.cx) + ($urandom_range(0, 1) ? gap : -gap));
         p.b.cy = COORD_W'(int'(p.a.cy) + int'($urandom_range(0, 2 * slide)) - slide);
      end else begin
         gap   = int'(p.a.half_h) + int'(p.b.half_h) + int'($urandom_range(0, 2)) - 1;
         slide = int'(p.a.half_w) + int'(p.b.half_w);
         p.b.cy = COORD_W'(int'(p.a.cy) + ($urandom_range(0, 1) ? gap : -gap));
         p.b.cx = COORD_W'(int'(p.a.cx) + int'($urandom_range(0, 2 * slide)) - slide);
      end
      return p;
   endfunction

   function automatic box_pair_type raw_pair();
      box_pair_type p;
      p.a = mk_box($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      p.b = mk_box($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      return p;
   endfunction

   task automatic report_failure(string msg);
      failures++;
      if (failures <= 10)
         $display("%s", msg);
   endtask

   // ------------------------------------------------------------------------
   // Driver: one word per accepted start, random gaps outside the quiet
   // window, and a hold until the pipeline is empty at two points.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      bit gap_now;
      bit drain_now;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            hit_expected_q.push_back(boxes_overlap(cur_pair));
            words_sent++;
         end
         if (!start || !busy) begin
            gap_now   = (words_sent < QUIET_FROM || words_sent >= QUIET_TO)
                        && $urandom_range(0, 99) < 38;
            drain_now = (words_sent == directed_words || words_sent == MID_DRAIN)
                        && hit_expected_q.size() != 0;
            if (pair_q.size() != 0 && !gap_now && !drain_now) begin
               cur_pair       = pair_q.pop_front();
               req_a_center_x <= cur_pair.a.cx;
               req_a_center_y <= cur_pair.a.cy;
               req_a_cos      <= cur_pair.a.cos_u;
               req_a_sin      <= cur_pair.a.sin_u;
               req_a_half_w   <= cur_pair.a.half_w;
               req_a_half_h   <= cur_pair.a.half_h;
               req_b_center_x <= cur_pair.b.cx;
               req_b_center_y <= cur_pair.b.cy;
               req_b_cos      <= cur_pair.b.cos_u;
               req_b_sin      <= cur_pair.b.sin_u;
               req_b_half_w   <= cur_pair.b.half_w;
               req_b_half_h   <= cur_pair.b.half_h;
               start          <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: every strobed word is checked against the oldest prediction.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      bit want;
      if (!reset && rsp_valid === 1'b1) begin
         if (hit_expected_q.size() == 0) begin
            report_failure($sformatf("rsp_valid with no word outstanding, rsp_hit=%b",
                                     rsp_hit));
         end else begin
            want = hit_expected_q.pop_front();
            if (rsp_hit !== want)
               report_failure($sformatf("result %0d: rsp_hit expected %0b got %b",
                                        results_seen, want, rsp_hit));
            results_seen++;
         end
      end
   end

   initial begin
      box_type sq;
      int      kind;
      words_sent   = 0;
      results_seen = 0;
      failures     = 0;
      sq = mk_box(0, 0, ONE_AXIS, 0, 256, 256);

      // Directed pairs: coincident points, coordinate and half-length extremes,
      // exact edge contact and one LSB past it, rotations, raw axis extremes
      // including the most negative component, degenerate segments and points.
      pair_q.push_back(mk_pair(mk_box(0, 0, 0, 0, 0, 0), mk_box(0, 0, 0, 0, 0, 0)));
      pair_q.push_back(mk_pair(mk_box(8388607, 8388607, ONE_AXIS, 0, 0, 0),
                               mk_box(-8388608, -8388608, ONE_AXIS, 0, 0, 0)));
      pair_q.push_back(mk_pair(mk_box(-8388608, -8388608, 0, ONE_AXIS, 8388607, 8388607),
                               mk_box(8388607, 8388607, -ONE_AXIS, 0, 8388607, 8388607)));
      pair_q.push_back(mk_pair(sq, mk_box(512, 0, ONE_AXIS, 0, 256, 256)));
      pair_q.push_back(mk_pair(sq, mk_box(513, 0, ONE_AXIS, 0, 256, 256)));
      pair_q.push_back(mk_pair(sq, mk_box(0, 512, ONE_AXIS, 0, 256, 256)));
      pair_q.push_back(mk_pair(sq, mk_box(0, -513, ONE_AXIS, 0, 256, 256)));
      pair_q.push_back(mk_pair(sq, mk_box(560, 560, 11585, 11585, 256, 256)));
      pair_q.push_back(mk_pair(sq, mk_box(400, 400, 11585, -11585, 256, 256)));
      pair_q.push_back(mk_pair(mk_box(100, -50, -32768, -32768, 8388607, 8388607),
                               mk_box(-100, 50, 32767, -32768, 8388607, 8388607)));
      pair_q.push_back(mk_pair(mk_box(0, 0, 0, -ONE_AXIS, 1000, 20),
                               mk_box(900, 0, -ONE_AXIS, 0, 30, 30)));
      pair_q.push_back(mk_pair(mk_box(0, 0, ONE_AXIS, 0, 1024, 0),
                               mk_box(1024, 0, 0, 0, 0, 0)));
      pair_q.push_back(mk_pair(mk_box(0, 0, ONE_AXIS, 0, 1024, 0),
                               mk_box(1025, 0, 0, 0, 0, 0)));
      pair_q.push_back(mk_pair(mk_box(5000, 5000, ONE_AXIS, 0, 100000, 100000),
                               mk_box(5100, 4900, 5000, 15000, 10, 20)));
      pair_q.push_back(mk_pair(mk_box(0, 0, ONE_AXIS, 0, 4000, 10),
                               mk_box(0, 0, ONE_AXIS, 0, 10, 4000)));
      pair_q.push_back(mk_pair(mk_box(8388607, -8388608, -32768, 32767, 8388607, 0),
                               mk_box(-8388608, 8388607, 32767, -32768, 0, 8388607)));
      pair_q.push_back(mk_pair(mk_box(-7, 3, 16384, 16384, 1, 1),
                               mk_box(7, -3, -16384, 16384, 1, 1)));
      directed_words = pair_q.size();

      for (int i = 0; i < RANDOM_N; i++) begin
         kind = $urandom_range(0, 99);
         if (kind < 45)
            pair_q.push_back(near_pair(4095, 1'b1));
         else if (kind < 65)
            pair_q.push_back(contact_pair());
         else if (kind < 85)
            pair_q.push_back(raw_pair());
         else
            pair_q.push_back(near_pair(1 << 20, 1'b0));
      end
      total_words = pair_q.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (words_sent < total_words)
         @(posedge clock);
      while (hit_expected_q.size() != 0)
         @(posedge clock);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
      if (failures == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
